[sv/gld_pkg.sv]
// ----------------------------------------------------------------------------
// gld_pkg
// Shared constants, types and helpers of the grid local maximum detector.
// ----------------------------------------------------------------------------
package gld_pkg;

	localparam int MAX_SIZE     = 32;
	localparam int VALUE_BITS   = 16;
	localparam int IDX_W        = $clog2(MAX_SIZE);
	localparam int SIZE_W       = 6;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = QPTR_W + 1;
	localparam int TDATA_IN_W   = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + 2 * IDX_W;
	localparam int TDATA_OUT_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_GRID_SIZE = 1'b0;

	// One accepted pixel, classified by the front end
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [IDX_W-1:0]             row;
		logic [IDX_W-1:0]             col;
		logic [IDX_W-1:0]             last_idx;
		logic                         sel;
		logic                         has_dec;
		logic                         final_cell;
	} gld_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CTR,
		BK_LEFT,
		BK_RIGHT,
		BK_EVAL
	} bk_state_t;

	// Index of the last row/column for a programmed grid size
	function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] size);
		logic [IDX_W-1:0] res;
		if (size == '0) begin
			res = '0;
		end else if (size > SIZE_W'(MAX_SIZE)) begin
			res = IDX_W'(MAX_SIZE - 1);
		end else begin
			res = IDX_W'(size - 1'b1);
		end
		return res;
	endfunction

endpackage

[sv/gld_front.sv]
// ----------------------------------------------------------------------------
// gld_front
// Accept pixels, track the raster position and tag each request for the back.
// ----------------------------------------------------------------------------
module gld_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_restart,
	input  logic [gld_pkg::SIZE_W-1:0]       grid_size,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gld_pkg::TDATA_IN_W-1:0]   s_tdata,   // [15:0] pixel_value
	input  gld_pkg::q_status_t               q_status,
	output logic                             push,
	output gld_pkg::gld_entry_t              push_entry
);

	logic [gld_pkg::IDX_W-1:0] row_q;
	logic [gld_pkg::IDX_W-1:0] col_q;
	logic                      sel_q;
	logic [gld_pkg::IDX_W-1:0] last_idx;
	logic                      row_end;
	logic                      grid_end;

	assign last_idx = gld_pkg::last_index(grid_size);
	assign row_end  = (col_q == last_idx);
	assign grid_end = row_end && (row_q == last_idx);
	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_entry            = '0;
		push_entry.value      = s_tdata[gld_pkg::VALUE_BITS-1:0];
		push_entry.row        = row_q;
		push_entry.col        = col_q;
		push_entry.last_idx   = last_idx;
		push_entry.sel        = sel_q;
		push_entry.has_dec    = (row_q != '0);
		push_entry.final_cell = grid_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			sel_q <= 1'b0;
		end else if (cfg_restart) begin
			row_q <= '0;
			col_q <= '0;
			sel_q <= 1'b0;
		end else if (push) begin
			if (grid_end) begin
				row_q <= '0;
				col_q <= '0;
				sel_q <= 1'b0;
			end else if (row_end) begin
				row_q <= row_q + 1'b1;
				col_q <= '0;
				sel_q <= !sel_q;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

[sv/gld_queue.sv]
// ----------------------------------------------------------------------------
// gld_queue
// Short request queue between front and back, head shown ahead of pop.
// ----------------------------------------------------------------------------
module gld_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  gld_pkg::gld_entry_t  push_entry,
	input  logic                 pop,
	output gld_pkg::gld_entry_t  head,
	output gld_pkg::q_status_t   status
);

	gld_pkg::gld_entry_t           slots_q [gld_pkg::QUEUE_DEPTH];
	logic [gld_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [gld_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [gld_pkg::QCNT_W-1:0]    count_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = (count_q == gld_pkg::QCNT_W'(gld_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty) else $error("queue pop while empty");

endmodule

[sv/gld_back.sv]
// ----------------------------------------------------------------------------
// gld_back
// Line buffers and decision sequencer; one buffer read per cycle per decision.
// ----------------------------------------------------------------------------
module gld_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gld_pkg::q_status_t               q_status,
	input  gld_pkg::gld_entry_t              head,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gld_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [0] is_peak, [5:1] cell_row,
	                                                    // [10:6] cell_col, rest zero
	output logic                             m_tlast    // grid_done
);

	localparam int VB = gld_pkg::VALUE_BITS;
	localparam int IW = gld_pkg::IDX_W;

	gld_pkg::bk_state_t   state_q;
	gld_pkg::bk_state_t   state_nx;
	gld_pkg::gld_entry_t  ent_q;
	logic [IW-1:0]        k_q;
	logic                 flush_q;

	logic signed [VB-1:0] buf_a [gld_pkg::MAX_SIZE];
	logic signed [VB-1:0] buf_b [gld_pkg::MAX_SIZE];
	logic signed [VB-1:0] rd_a_q;
	logic signed [VB-1:0] rd_b_q;
	logic signed [VB-1:0] ctr_q;
	logic signed [VB-1:0] up_q;
	logic signed [VB-1:0] left_q;
	logic signed [VB-1:0] rd_x;
	logic signed [VB-1:0] rd_y;

	logic                 out_valid_q;
	logic                 is_peak_q;
	logic [IW-1:0]        cell_row_q;
	logic [IW-1:0]        cell_col_q;
	logic                 grid_done_q;

	logic                 rd_en;
	logic                 wr_en;
	logic                 cap_mid;
	logic                 cap_left;
	logic                 load_out;
	logic                 start_flush;
	logic                 step_k;
	logic [IW-1:0]        x_addr;
	logic [IW-1:0]        addr_a;
	logic [IW-1:0]        addr_b;
	logic                 x_is_a;
	logic                 out_free;
	logic                 k_last;
	logic                 has_up;
	logic                 peak;

	// X is the row being decided, Y the row above it
	assign x_is_a   = !(ent_q.sel ^ flush_q);
	assign addr_a   = x_is_a ? x_addr : k_q;
	assign addr_b   = x_is_a ? k_q : x_addr;
	assign rd_x     = x_is_a ? rd_a_q : rd_b_q;
	assign rd_y     = x_is_a ? rd_b_q : rd_a_q;
	assign out_free = !out_valid_q || m_tready;
	assign k_last   = (k_q == ent_q.last_idx);
	assign has_up   = flush_q ? (ent_q.last_idx != '0) : (ent_q.row > IW'(1));

	always_comb begin
		peak = 1'b1;
		if (has_up && !(ctr_q > up_q)) begin
			peak = 1'b0;
		end
		if (!flush_q && !(ctr_q > ent_q.value)) begin
			peak = 1'b0;
		end
		if ((k_q != '0) && !(ctr_q > left_q)) begin
			peak = 1'b0;
		end
		if (!k_last && !(ctr_q > rd_x)) begin
			peak = 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			gld_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					state_nx = gld_pkg::BK_CTR;
				end
			end
			gld_pkg::BK_CTR: begin
				if (!flush_q && !ent_q.has_dec) begin
					state_nx = ent_q.final_cell ? gld_pkg::BK_CTR : gld_pkg::BK_IDLE;
				end else begin
					state_nx = gld_pkg::BK_LEFT;
				end
			end
			gld_pkg::BK_LEFT:  state_nx = gld_pkg::BK_RIGHT;
			gld_pkg::BK_RIGHT: state_nx = gld_pkg::BK_EVAL;
			gld_pkg::BK_EVAL: begin
				if (out_free) begin
					if (flush_q) begin
						state_nx = k_last ? gld_pkg::BK_IDLE : gld_pkg::BK_CTR;
					end else begin
						state_nx = ent_q.final_cell ? gld_pkg::BK_CTR : gld_pkg::BK_IDLE;
					end
				end
			end
			default: state_nx = gld_pkg::BK_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop         = 1'b0;
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		cap_mid     = 1'b0;
		cap_left    = 1'b0;
		load_out    = 1'b0;
		start_flush = 1'b0;
		step_k      = 1'b0;
		x_addr      = k_q;
		case (state_q)
			gld_pkg::BK_IDLE: begin
				pop = !q_status.empty;
			end
			gld_pkg::BK_CTR: begin
				rd_en       = 1'b1;
				wr_en       = !flush_q;
				start_flush = !flush_q && !ent_q.has_dec && ent_q.final_cell;
			end
			gld_pkg::BK_LEFT: begin
				rd_en   = 1'b1;
				cap_mid = 1'b1;
				x_addr  = IW'(k_q - 1'b1);
			end
			gld_pkg::BK_RIGHT: begin
				rd_en    = 1'b1;
				cap_left = 1'b1;
				x_addr   = IW'(k_q + 1'b1);
			end
			gld_pkg::BK_EVAL: begin
				load_out    = out_free;
				start_flush = out_free && !flush_q && ent_q.final_cell;
				step_k      = out_free && flush_q && !k_last;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Line buffers: registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= buf_a[addr_a];
			rd_b_q <= buf_b[addr_b];
		end
		if (wr_en && ent_q.sel) begin
			buf_a[ent_q.col] <= ent_q.value;
		end
		if (wr_en && !ent_q.sel) begin
			buf_b[ent_q.col] <= ent_q.value;
		end
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
			k_q   <= head.col;
		end else if (start_flush) begin
			k_q <= '0;
		end else if (step_k) begin
			k_q <= k_q + 1'b1;
		end
		if (cap_mid) begin
			ctr_q <= rd_x;
			up_q  <= rd_y;
		end
		if (cap_left) begin
			left_q <= rd_x;
		end
		if (load_out) begin
			is_peak_q   <= peak;
			cell_row_q  <= flush_q ? ent_q.row : IW'(ent_q.row - 1'b1);
			cell_col_q  <= k_q;
			grid_done_q <= flush_q && k_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gld_pkg::BK_IDLE;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (pop) begin
				flush_q <= 1'b0;
			end else if (start_flush) begin
				flush_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = grid_done_q;
	always_comb begin
		m_tdata                     = '0;
		m_tdata[0]                  = is_peak_q;
		m_tdata[IW:1]               = cell_row_q;
		m_tdata[2*IW:IW+1]          = cell_col_q;
	end

	a_done_on_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && grid_done_q) |-> (cell_row_q == cell_col_q))
		else $error("grid_done off the final corner cell");

	a_flush_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (k_q <= ent_q.last_idx))
		else $error("flush column past the last column");

	a_eval_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gld_pkg::BK_EVAL && !out_free) |=>
		(state_q == gld_pkg::BK_EVAL && out_valid_q))
		else $error("decision lost while output stalled");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == gld_pkg::BK_CTR && !flush_q))
		else $error("popped request did not start a fresh decision");

endmodule

[sv/grid_local_maximum_detector.sv]
// ----------------------------------------------------------------------------
// grid_local_maximum_detector
// 4-neighbour strict local maximum marking over an N-by-N raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ stream in row-major order, one signed value per
//   request. Decisions leave on the m_ stream in row-major order, one row
//   behind the input: pixel (r,c) with r >= 1 releases the decision for
//   (r-1,c); the final pixel releases that one plus the whole last row.
//   m_tlast marks the decision for the final corner cell.
//   grid_size (APB, byte address 0) sets N; 0 acts as 1, above 32 as 32.
//   Any write to it restarts the raster; write it only while idle.
// Timing:
//   A front stage tags each pixel and parks it in a 4-entry queue. The back
//   sequencer reads the two line buffers one address each per cycle: a row-0
//   pixel passes the idle and centre states, a pixel with a decision idle,
//   centre, left, right and evaluate, and each cell of the final-row flush
//   centre, left, right and evaluate; evaluate waits while the output stalls.
//   A stalled m_tready holds the output register; the queue keeps taking
//   pixels until it fills, then s_tready drops.
// Reset:
//   Clears counters, queue and sequencer; grid_size returns to 32. Line
//   buffers need no clearing since no value is used before it is written.
// ----------------------------------------------------------------------------
module grid_local_maximum_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	// Pixel input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [gld_pkg::TDATA_IN_W-1:0]    s_tdata,   // [15:0] pixel_value
	// Decision output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gld_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [0] is_peak, [5:1] cell_row,
	                                                     // [10:6] cell_col, rest zero
	output logic                              m_tlast,   // grid_done
	// Configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gld_pkg::PADDR_W-1:0]       paddr,
	input  logic [gld_pkg::PDATA_W-1:0]       pwdata,
	output logic [gld_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	logic [gld_pkg::SIZE_W-1:0] grid_size_q;
	logic                       cfg_write;
	logic                       size_write;

	gld_pkg::q_status_t         q_status;
	gld_pkg::gld_entry_t        push_entry;
	gld_pkg::gld_entry_t        head;
	logic                       push;
	logic                       pop;

	// APB: zero-wait access, register index in paddr[2]
	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite && pready;
	assign size_write = cfg_write && (paddr[2] == gld_pkg::REG_GRID_SIZE);

	always_comb begin
		prdata = '0;
		if (paddr[2] == gld_pkg::REG_GRID_SIZE) begin
			prdata[gld_pkg::SIZE_W-1:0] = grid_size_q;
		end
	end

	// Hold the grid size; reset to the full grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= gld_pkg::SIZE_W'(gld_pkg::MAX_SIZE);
		end else if (size_write) begin
			grid_size_q <= pwdata[gld_pkg::SIZE_W-1:0];
		end
	end

	// Tag pixels with their raster position
	gld_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_restart (size_write),
		.grid_size   (grid_size_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.q_status    (q_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	// Decouple acceptance from buffer work
	gld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// Decide cells and drive the output register
	gld_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
